@@ src/tgbla_pkg.sv @@
package tgbla_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADMITTED = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DEPARTED = 3'd2,
    ST_BAD      = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Request opcodes
  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_DEPART = 1'b1
  } opcode_t;

  // Owner codes
  typedef enum logic [1:0] {
    OWN_NONE = 2'd0,
    OWN_G0   = 2'd1,
    OWN_G1   = 2'd2
  } owner_t;

  localparam logic [7:0] BATCH_LIMIT_RST = 8'd4;

  // Owner code that belongs to a group.
  function automatic owner_t owner_of(input logic grp);
    owner_t o;
    o = grp ? OWN_G1 : OWN_G0;
    return o;
  endfunction

endpackage

@@ src/two_group_batch_limited_arbiter.sv @@
// Results are registered: a request accepted at a clock edge shows its result in the next cycle.
// Throughput: one request per cycle while out_ready holds; the arbiter state updates at the accept edge
// and the result sits in an output register, so a new request is taken while a
// finished result waits as long as that register is being emptied the same cycle.
// Reset (synchronous, active high): no one inside, no waiters, batch count zero,
// owner none, batch_limit back to 4, output register empty.
module two_group_batch_limited_arbiter #(
  parameter int COUNT_MAX = 255
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: batch_limit
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic       group,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] admitted_waiters,
  output logic [1:0] owner_now,
  output logic [7:0] occupancy_now,
  output logic [7:0] waiting_zero_now,
  output logic [7:0] waiting_one_now
);

  // Counter cap: the smaller of COUNT_MAX and the 8-bit counter range.
  localparam int         CAP_INT = (COUNT_MAX > 255) ? 255 : COUNT_MAX;
  localparam logic [7:0] CAP     = CAP_INT[7:0];

  // Arbiter state
  logic [7:0]            batch_limit;
  logic [7:0]            wait0, wait1;
  logic [7:0]            occupancy;
  logic [7:0]            batch_count;
  tgbla_pkg::owner_t     owner;

  logic [7:0]            wait0_next, wait1_next;
  logic [7:0]            occupancy_next;
  logic [7:0]            batch_count_next;
  tgbla_pkg::owner_t     owner_next;
  tgbla_pkg::status_t    status_next;
  logic [7:0]            admitted_next;

  // Per-request decode
  logic                  accept;
  logic [7:0]            lim_eff;
  logic [7:0]            wait_own, wait_oth;
  logic                  can_enter;
  logic [7:0]            occ_dec;
  logic [7:0]            n_lim, n_cap;
  logic                  own_wait;

  // The output register frees up when empty or drained this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // A zero limit behaves as one.
  assign lim_eff  = (batch_limit == 8'd0) ? 8'd1 : batch_limit;

  assign wait_own = group ? wait1 : wait0;
  assign wait_oth = group ? wait0 : wait1;
  assign own_wait = (wait_own != 8'd0);
  assign occ_dec  = occupancy - 8'd1;

  // An arrival enters unless the other group holds the resource, the batch is
  // used up, or the occupancy counter is at its cap.
  assign can_enter = (owner != tgbla_pkg::owner_of(~group))
                  && (batch_count < lim_eff)
                  && (occupancy < CAP);

  // Handover size: all waiters of the other group, trimmed to the batch limit
  // when the departing group still waits, then to the cap.
  assign n_lim = (own_wait && (wait_oth > lim_eff)) ? lim_eff : wait_oth;
  assign n_cap = (n_lim > CAP) ? CAP : n_lim;

  always_comb begin
    wait0_next       = wait0;
    wait1_next       = wait1;
    occupancy_next   = occupancy;
    batch_count_next = batch_count;
    owner_next       = owner;
    admitted_next    = 8'd0;
    status_next      = tgbla_pkg::ST_BAD;

    if (opcode == tgbla_pkg::OP_ARRIVE) begin
      if (can_enter) begin
        occupancy_next = occupancy + 8'd1;
        owner_next     = tgbla_pkg::owner_of(group);
        // Count entries made while the other group waits.
        if ((wait_oth != 8'd0) && (batch_count != 8'd255)) begin
          batch_count_next = batch_count + 8'd1;
        end
        status_next = tgbla_pkg::ST_ADMITTED;
      end else if (wait_own < CAP) begin
        if (group) begin
          wait1_next = wait1 + 8'd1;
        end else begin
          wait0_next = wait0 + 8'd1;
        end
        status_next = tgbla_pkg::ST_QUEUED;
      end else begin
        status_next = tgbla_pkg::ST_FULL;
      end
    end else begin
      if ((occupancy == 8'd0) || (owner != tgbla_pkg::owner_of(group))) begin
        status_next = tgbla_pkg::ST_BAD;
      end else begin
        occupancy_next = occ_dec;
        status_next    = tgbla_pkg::ST_DEPARTED;
        if (occ_dec == 8'd0) begin
          if (wait_oth != 8'd0) begin
            // Last one out: hand the resource to the waiting group.
            if (group) begin
              wait0_next = wait0 - n_cap;
            end else begin
              wait1_next = wait1 - n_cap;
            end
            occupancy_next   = n_cap;
            owner_next       = tgbla_pkg::owner_of(~group);
            batch_count_next = own_wait ? n_cap : 8'd0;
            admitted_next    = n_cap;
          end else begin
            owner_next       = tgbla_pkg::OWN_NONE;
            batch_count_next = 8'd0;
          end
        end
      end
    end
  end

  // State and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_limit <= tgbla_pkg::BATCH_LIMIT_RST;
      wait0       <= 8'd0;
      wait1       <= 8'd0;
      occupancy   <= 8'd0;
      batch_count <= 8'd0;
      owner       <= tgbla_pkg::OWN_NONE;
    end else begin
      if (cfg_we) begin
        batch_limit <= cfg_wdata;
      end
      if (accept) begin
        wait0       <= wait0_next;
        wait1       <= wait1_next;
        occupancy   <= occupancy_next;
        batch_count <= batch_count_next;
        owner       <= owner_next;
      end
    end
  end

  // Output register: valid is control, the payload loads on accept only.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status           <= status_next;
      admitted_waiters <= admitted_next;
      owner_now        <= owner_next;
      occupancy_now    <= occupancy_next;
      waiting_zero_now <= wait0_next;
      waiting_one_now  <= wait1_next;
    end
  end

endmodule

@@ src/tgbla_checker.sv @@
module tgbla_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] admitted_waiters,
  input logic [1:0] owner_now,
  input logic [7:0] occupancy_now
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy_now))
    else $error("result changed while stalled");

  // Space in the output stage means a request can enter.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // Occupancy and ownership agree.
  a_owner_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((owner_now == tgbla_pkg::OWN_NONE) == (occupancy_now == 8'd0)))
    else $error("owner and occupancy disagree");

  // A handover only on a departure, and the admitted batch is all that is inside.
  a_handover: assert property (@(posedge clk) disable iff (rst)
    out_valid && (admitted_waiters != 8'd0) |->
      (status == tgbla_pkg::ST_DEPARTED) && (occupancy_now == admitted_waiters))
    else $error("bad handover result");

endmodule

bind two_group_batch_limited_arbiter tgbla_checker u_tgbla_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .admitted_waiters (admitted_waiters),
  .owner_now        (owner_now),
  .occupancy_now    (occupancy_now)
);

@@ sim/tb_two_group_batch_limited_arbiter.sv @@
`timescale 1ns / 100ps

module tb_two_group_batch_limited_arbiter;

  // Every counter of the arbiter saturates here with the default COUNT_MAX.
  localparam logic [7:0] CNT_CAP = 8'd255;

  // Long receiver hold-off: start it once this many results have come.
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 80;

  localparam int RAND_PHASES   = 5;
  localparam int RAND_PER_PHASE = 52;

  // One result as the arbiter reports it.
  typedef struct packed {
    tgbla_pkg::status_t status;
    logic [7:0]         admitted;
    tgbla_pkg::owner_t  owner;
    logic [7:0]         occupancy;
    logic [7:0]         waiting0;
    logic [7:0]         waiting1;
  } arb_result_t;

  // One row of the directed table. A typed row carries its own expected
  // result; all others are checked against the predictor.
  typedef struct packed {
    tgbla_pkg::opcode_t op;
    logic               grp;
    logic               typed;
    arb_result_t        want;
  } dir_row_t;

  localparam arb_result_t NO_RES = '0;

  // Runs at the reset batch limit of 4.
  localparam dir_row_t DIRECTED_ROWS [21] = '{
    // departure with nobody inside
    '{tgbla_pkg::OP_DEPART, 1'b0, 1'b1,
      '{tgbla_pkg::ST_BAD, 8'd0, tgbla_pkg::OWN_NONE, 8'd0, 8'd0, 8'd0}},
    // first arrival takes the free resource
    '{tgbla_pkg::OP_ARRIVE, 1'b0, 1'b1,
      '{tgbla_pkg::ST_ADMITTED, 8'd0, tgbla_pkg::OWN_G0, 8'd1, 8'd0, 8'd0}},
    // other group must wait
    '{tgbla_pkg::OP_ARRIVE, 1'b1, 1'b1,
      '{tgbla_pkg::ST_QUEUED, 8'd0, tgbla_pkg::OWN_G0, 8'd1, 8'd0, 8'd1}},
    // departure by the group that does not own the resource
    '{tgbla_pkg::OP_DEPART, 1'b1, 1'b1,
      '{tgbla_pkg::ST_BAD, 8'd0, tgbla_pkg::OWN_G0, 8'd1, 8'd0, 8'd1}},
    // own-group entries while group 1 waits: batch counter climbs to the limit
    '{tgbla_pkg::OP_ARRIVE, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_ARRIVE, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_ARRIVE, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_ARRIVE, 1'b0, 1'b0, NO_RES},
    // batch limit reached: own group is queued too
    '{tgbla_pkg::OP_ARRIVE, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_ARRIVE, 1'b1, 1'b0, NO_RES},
    // drain group 0; the last one hands over to group 1 with both waiting
    '{tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES},
    // drain group 1; hand back to group 0 with no own waiters
    '{tgbla_pkg::OP_DEPART, 1'b1, 1'b0, NO_RES},
    '{tgbla_pkg::OP_DEPART, 1'b1, 1'b0, NO_RES},
    // last one out with nobody waiting: resource goes idle
    '{tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES},
    '{tgbla_pkg::OP_ARRIVE, 1'b1, 1'b0, NO_RES},
    '{tgbla_pkg::OP_DEPART, 1'b1, 1'b0, NO_RES},
    '{tgbla_pkg::OP_DEPART, 1'b1, 1'b1,
      '{tgbla_pkg::ST_BAD, 8'd0, tgbla_pkg::OWN_NONE, 8'd0, 8'd0, 8'd0}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       opcode = 1'b0;
  logic       group = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] status;
  logic [7:0] admitted_waiters;
  logic [1:0] owner_now;
  logic [7:0] occupancy_now;
  logic [7:0] waiting_zero_now;
  logic [7:0] waiting_one_now;

  two_group_batch_limited_arbiter u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .group            (group),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .admitted_waiters (admitted_waiters),
    .owner_now        (owner_now),
    .occupancy_now    (occupancy_now),
    .waiting_zero_now (waiting_zero_now),
    .waiting_one_now  (waiting_one_now)
  );

  // Arbiter state as the predictor sees it, plus the batch limit last written.
  logic [7:0]        limit_reg   = tgbla_pkg::BATCH_LIMIT_RST;
  logic [7:0]        queued_cnt [2] = '{8'd0, 8'd0};
  logic [7:0]        inside_cnt  = 8'd0;
  logic [7:0]        batch_cnt   = 8'd0;
  tgbla_pkg::owner_t holder      = tgbla_pkg::OWN_NONE;

  arb_result_t pending_results [$];

  // Idling controls, flipped per phase by the stimulus process.
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;

  int mismatches    = 0;
  int results_seen  = 0;
  int requests_sent = 0;
  int handovers     = 0;
  int limit_writes  = 0;
  int status_seen [8] = '{default: 0};

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic tgbla_pkg::owner_t group_code(input logic grp);
    return grp ? tgbla_pkg::OWN_G1 : tgbla_pkg::OWN_G0;
  endfunction

  // Apply one accepted request to the predicted state; return its result.
  function automatic arb_result_t arbitrate(input tgbla_pkg::opcode_t op, input logic grp);
    arb_result_t res;
    logic        oth;
    logic [7:0]  lim;
    logic [7:0]  n;
    bit          own_wait;
    oth = ~grp;
    lim = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
    res = '0;
    if (op == tgbla_pkg::OP_ARRIVE) begin
      if (holder != group_code(oth) && batch_cnt < lim && inside_cnt < CNT_CAP) begin
        inside_cnt = inside_cnt + 8'd1;
        holder = group_code(grp);
        // count entries made while the other side is kept waiting
        if (queued_cnt[oth] != 8'd0 && batch_cnt != 8'd255)
          batch_cnt = batch_cnt + 8'd1;
        res.status = tgbla_pkg::ST_ADMITTED;
      end else if (queued_cnt[grp] < CNT_CAP) begin
        queued_cnt[grp] = queued_cnt[grp] + 8'd1;
        res.status = tgbla_pkg::ST_QUEUED;
      end else begin
        res.status = tgbla_pkg::ST_FULL;
      end
    end else if (inside_cnt == 8'd0 || holder != group_code(grp)) begin
      res.status = tgbla_pkg::ST_BAD;
    end else begin
      inside_cnt = inside_cnt - 8'd1;
      res.status = tgbla_pkg::ST_DEPARTED;
      if (inside_cnt == 8'd0) begin
        if (queued_cnt[oth] != 8'd0) begin
          // hand over: admit the other side's waiters, batched if we still wait
          n = queued_cnt[oth];
          own_wait = (queued_cnt[grp] != 8'd0);
          if (own_wait && n > lim)
            n = lim;
          queued_cnt[oth] = queued_cnt[oth] - n;
          inside_cnt = n;
          holder = group_code(oth);
          batch_cnt = own_wait ? n : 8'd0;
          res.admitted = n;
        end else begin
          holder = tgbla_pkg::OWN_NONE;
          batch_cnt = 8'd0;
        end
      end
    end
    res.owner     = holder;
    res.occupancy = inside_cnt;
    res.waiting0  = queued_cnt[0];
    res.waiting1  = queued_cnt[1];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 2);
    else if (r < 95)
      return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    $display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, what,
             got, want);
  endtask

  // Offer one request and hold it until accepted; predict at the accept edge.
  // Enter and leave at a rising edge. Valid is only lowered when a gap
  // follows, so back-to-back requests keep it high.
  task automatic send_req(input tgbla_pkg::opcode_t op, input logic grp,
                          input logic use_typed, input arb_result_t typed);
    arb_result_t pred;
    int          gap;
    gap = (tx_gaps_on && $urandom_range(0, 99) < 40) ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    group    <= grp;
    do @(posedge clk); while (!in_ready);
    pred = arbitrate(op, grp);
    pending_results.push_back(use_typed ? typed : pred);
    requests_sent++;
  endtask

  // Drop valid and hold the sender until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_batch_limit(input logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
    limit_writes++;
  endtask

  // Random request biased toward well-formed traffic: mostly departures by
  // the owner group and arrivals of either group, with a little noise.
  task automatic send_random_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)
      send_req(tgbla_pkg::opcode_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'b0, NO_RES);
    else if (inside_cnt != 8'd0 && r < 56)
      send_req(tgbla_pkg::OP_DEPART, holder == tgbla_pkg::OWN_G1, 1'b0, NO_RES);
    else
      send_req(tgbla_pkg::OP_ARRIVE, 1'($urandom_range(0, 1)), 1'b0, NO_RES);
  endtask

  // Result side: check each accepted result against the oldest expectation,
  // then decide whether to stall next cycle.
  initial begin : result_check
    arb_result_t want;
    int          stall;
    bit          held;
    stall = 0;
    held  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        status_seen[status]++;
        if (admitted_waiters != 8'd0)
          handovers++;
        if (pending_results.size() == 0) begin
          note_mismatch("unrequested result, status", status, 0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            note_mismatch("status", status, want.status);
          if (admitted_waiters !== want.admitted)
            note_mismatch("admitted_waiters", admitted_waiters, want.admitted);
          if (owner_now !== want.owner)
            note_mismatch("owner_now", owner_now, want.owner);
          if (occupancy_now !== want.occupancy)
            note_mismatch("occupancy_now", occupancy_now, want.occupancy);
          if (waiting_zero_now !== want.waiting0)
            note_mismatch("waiting_zero_now", waiting_zero_now, want.waiting0);
          if (waiting_one_now !== want.waiting1)
            note_mismatch("waiting_one_now", waiting_one_now, want.waiting1);
        end
      end
      if (!held && results_seen == HOLD_AT) begin
        // hold off long enough for the output to back up into the input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 99) < 25) begin
        stall = gap_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] lim_plan [RAND_PHASES];
    int         k;
    int         ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table at the reset batch limit.
    for (k = 0; k < 21; k++)
      send_req(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].grp, DIRECTED_ROWS[k].typed,
               DIRECTED_ROWS[k].want);

    // Saturation run at the widest batch limit: overflow group 1's waiter
    // count into a rejection, hand all of it over at once so the resource
    // sits at the occupancy cap, queue one more of each group, then drain.
    set_batch_limit(8'd255);
    send_req(tgbla_pkg::OP_ARRIVE, 1'b0, 1'b0, NO_RES);
    for (k = 0; k < 256; k++)
      send_req(tgbla_pkg::OP_ARRIVE, 1'b1, 1'b0, NO_RES);
    send_req(tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES);
    send_req(tgbla_pkg::OP_ARRIVE, 1'b1, 1'b0, NO_RES);
    send_req(tgbla_pkg::OP_ARRIVE, 1'b0, 1'b0, NO_RES);
    for (k = 0; k < 255; k++)
      send_req(tgbla_pkg::OP_DEPART, 1'b1, 1'b0, NO_RES);
    send_req(tgbla_pkg::OP_DEPART, 1'b0, 1'b0, NO_RES);
    send_req(tgbla_pkg::OP_DEPART, 1'b1, 1'b0, NO_RES);

    // Random mixes over several batch limits, the extremes among them.
    lim_plan[0] = 8'd1;
    lim_plan[1] = 8'd2;
    lim_plan[2] = 8'($urandom_range(3, 10));
    lim_plan[3] = 8'd255;
    lim_plan[4] = 8'($urandom_range(1, 255));
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_batch_limit(lim_plan[ph]);
      // first phase runs flat out on both sides
      tx_gaps_on = (ph != 0);
      rx_gaps_on = (ph != 0 && ph != 2);
      for (k = 0; k < RAND_PER_PHASE; k++)
        send_random_req();
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d requests over %0d batch limit writes, %0d handovers",
             requests_sent, limit_writes, handovers);
    $display("Statuses: %0d admitted, %0d queued, %0d departed, %0d bad, %0d rejected",
             status_seen[tgbla_pkg::ST_ADMITTED], status_seen[tgbla_pkg::ST_QUEUED],
             status_seen[tgbla_pkg::ST_DEPARTED], status_seen[tgbla_pkg::ST_BAD],
             status_seen[tgbla_pkg::ST_FULL]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tgbla_pkg.sv
src/two_group_batch_limited_arbiter.sv
src/tgbla_checker.sv
sim/tb_two_group_batch_limited_arbiter.sv
